// File: design/rkc_pkg.sv
package rkc_pkg;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_PIXEL = 2'd1,
		FUNC_DRAIN = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH   = 2'd0,
		CFG_FRAME_HEIGHT  = 2'd1,
		CFG_KERNEL_WIDTH  = 2'd2,
		CFG_KERNEL_HEIGHT = 2'd3
	} cfg_idx_t;

	localparam int CFG_DATA_W = 13;

	typedef struct packed {
		logic [1:0]         func;
		logic [5:0]         coef_index;
		logic signed [15:0] coef_value;
		logic [7:0]         in_red;
		logic [7:0]         in_green;
		logic [7:0]         in_blue;
		logic [7:0]         in_alpha;
	} pix_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       frame_done;
	} res_t;

endpackage

// File: design/rgb_kernel_convolution.sv
// RGBA raster convolution with a loadable kernel of up to MAX_KERNEL x MAX_KERNEL taps.
// Input channel pix (valid/ready): func selects a coefficient load, a pixel or a drain.
// Output channel res (valid/ready): one filtered pixel; frame_done marks the last of a frame.
// Config port cfg_we/cfg_index/cfg_data: frame and kernel sizes; any write restarts the frame.
// A pixel that causes no result, a drain with nothing owed or an ignored item leaves pix_ready high.
// An item that causes a result runs the tap loop over kw*kh taps and then the divider for
// each channel (the divider is skipped when the kernel sums to zero).
// The tap loop reads one pixel and one coefficient per cycle from the two memories;
// the divider resolves one quotient bit per cycle.
// A coefficient load or a config write starts a sweep over the coefficient memory that
// rebuilds the kernel sum; pix_ready is low during it.
// The result for pixel o appears once pixel o + (kh/2)*width + kw/2 has been transferred;
// drain items flush the rest of the frame.
// The result sits in an output register: a stalled receiver does not block the next input
// transfer, but the next result waits until the held one is taken.
// After reset the sizes are 1024x1024 with a 3x3 kernel of zero coefficients.
module rgb_kernel_convolution #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_KERNEL = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_ready,
	input  rkc_pkg::pix_t                      pix,
	output logic                               res_valid,
	input  logic                               res_ready,
	output rkc_pkg::res_t                      res,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [rkc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int COEF_COUNT = MAX_KERNEL * MAX_KERNEL;
	localparam int CA_W    = (COEF_COUNT > 1) ? $clog2(COEF_COUNT) : 1;
	localparam int CC_W    = $clog2(COEF_COUNT + 1);
	localparam int W_W     = $clog2(MAX_WIDTH + 1);
	localparam int K_W     = $clog2(MAX_KERNEL + 1);
	localparam int POS_W   = W_W + 13;
	localparam int RSPAN   = (MAX_KERNEL - 1) * MAX_WIDTH + MAX_KERNEL;
	localparam int RING_AW = (RSPAN > 1) ? $clog2(RSPAN) : 1;
	localparam int XS_W    = W_W + K_W + 1;
	localparam int YS_W    = 13 + K_W + 1;
	localparam int ACC_W   = 25 + CC_W;
	localparam int TOT_W   = 16 + CC_W;
	localparam int NUM_W   = ACC_W + 2;
	localparam int DEN_W   = TOT_W + 1;

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b0000000001,
		ST_SWEEP     = 10'b0000000010,
		ST_SWEEP_END = 10'b0000000100,
		ST_START     = 10'b0000001000,
		ST_TAP       = 10'b0000010000,
		ST_TAP_END   = 10'b0000100000,
		ST_DIV_INIT  = 10'b0001000000,
		ST_DIV_CHK   = 10'b0010000000,
		ST_DIV_STEP  = 10'b0100000000,
		ST_FIN       = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [10:0] fw_q;
	logic [12:0] fh_q;
	logic [2:0]  kw_q;
	logic [2:0]  kh_q;

	logic [31:0]       ring_mem [2**RING_AW];
	logic [31:0]       ring_rd_q;
	logic signed [15:0] coef_mem [COEF_COUNT];
	logic signed [15:0] coef_rd_q;
	logic [COEF_COUNT-1:0] coef_vld_q;

	logic signed [TOT_W-1:0] coef_total_q;
	logic signed [TOT_W-1:0] sweep_acc_q;
	logic [CC_W-1:0]         sc_q;
	logic                    sweep_s1;
	logic [CC_W-1:0]         sidx_s1;
	logic                    cvld_s1;

	logic [POS_W-1:0] in_pos_q;
	logic [POS_W-1:0] out_pos_q;
	logic [W_W-1:0]   out_x_q;
	logic [12:0]      out_y_q;

	logic signed [XS_W-1:0] tap_x_q;
	logic signed [YS_W-1:0] tap_y_q;
	logic [RING_AW-1:0]     row_addr_q;
	logic [RING_AW-1:0]     tap_addr_q;
	logic [K_W-1:0]         kx_q;
	logic [K_W-1:0]         ky_q;
	logic [CC_W-1:0]        ci_q;
	logic                   tap_s1;
	logic                   alpha_s1;
	logic [7:0]             alpha_q;
	logic signed [ACC_W-1:0] acc_q [3];

	logic [1:0]              ch_q;
	logic signed [NUM_W-1:0] num_q;
	logic [DEN_W-1:0]        den_q;
	logic [NUM_W-1:0]        rem_q;
	logic [NUM_W-1:0]        dsh_q;
	logic [2:0]              bit_q;
	logic [7:0]              quo_q;
	logic [7:0]              chan_q [3];

	logic                    res_valid_q;
	rkc_pkg::res_t           res_q;

	logic [W_W-1:0]   eff_fw;
	logic [12:0]      eff_fh;
	logic [K_W-1:0]   eff_kw;
	logic [K_W-1:0]   eff_kh;
	logic [K_W-1:0]   hw;
	logic [K_W-1:0]   hh;
	logic [CC_W-1:0]  n_taps;
	logic [POS_W-1:0] total;
	logic [POS_W-1:0] lag;
	logic [POS_W-1:0] in_next;

	logic pix_xfer;
	logic pix_take;
	logic emit_px;
	logic emit_drain;
	logic idx_ok;
	logic ring_we;
	logic coef_we;
	logic tap_ok;
	logic last_col;
	logic last_row;
	logic out_free;
	logic last_out;

	logic [RING_AW-1:0] ring_waddr;
	logic [RING_AW-1:0] ring_raddr;
	logic [CA_W-1:0]    coef_raddr;

	logic signed [15:0]      coef_use;
	logic signed [24:0]      prod [3];
	logic signed [TOT_W-1:0] sweep_next;
	logic signed [ACC_W-1:0] sum_sel;
	logic signed [ACC_W:0]   zs;
	logic [7:0]              zsat;
	logic signed [NUM_W-1:0] n2;
	logic signed [TOT_W:0]   tabs;
	logic [NUM_W-1:0]        lim;

	always_comb begin
		eff_fw = (fw_q == 11'd0) ? W_W'(1) :
			((32'(fw_q) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(fw_q));
		eff_fh = (fh_q == 13'd0) ? 13'd1 : fh_q;
		eff_kw = (kw_q == 3'd0) ? K_W'(1) :
			((32'(kw_q) > MAX_KERNEL) ? K_W'(MAX_KERNEL) : K_W'(kw_q));
		eff_kh = (kh_q == 3'd0) ? K_W'(1) :
			((32'(kh_q) > MAX_KERNEL) ? K_W'(MAX_KERNEL) : K_W'(kh_q));
		hw = eff_kw >> 1;
		hh = eff_kh >> 1;
		n_taps = CC_W'(eff_kw) * CC_W'(eff_kh);
		total = POS_W'(eff_fw) * POS_W'(eff_fh);
		lag = POS_W'(hh) * POS_W'(eff_fw) + POS_W'(hw);
		in_next = in_pos_q + POS_W'(1);
	end

	assign pix_ready = (state_q == ST_IDLE);
	assign pix_xfer = pix_valid & pix_ready;
	assign idx_ok = 32'(pix.coef_index) < COEF_COUNT;
	assign pix_take = (pix.func == rkc_pkg::FUNC_PIXEL) && (in_pos_q < total);
	assign emit_px = pix_take && ((in_next >= total) ||
		({1'b0, in_next} > ({1'b0, out_pos_q} + {1'b0, lag})));
	assign emit_drain = !pix_take &&
		((pix.func == rkc_pkg::FUNC_PIXEL) || (pix.func == rkc_pkg::FUNC_DRAIN)) &&
		(in_pos_q >= total) && (out_pos_q < total);
	assign ring_we = pix_xfer && pix_take;
	assign coef_we = pix_xfer && (pix.func == rkc_pkg::FUNC_LOAD) && idx_ok;
	assign ring_waddr = in_pos_q[RING_AW-1:0];
	assign ring_raddr = (state_q == ST_START) ? out_pos_q[RING_AW-1:0] : tap_addr_q;
	assign coef_raddr = (state_q == ST_SWEEP) ? sc_q[CA_W-1:0] : ci_q[CA_W-1:0];

	assign tap_ok = (tap_y_q >= 0) && (tap_y_q < $signed(YS_W'(eff_fh))) &&
		(tap_x_q >= 0) && (tap_x_q < $signed(XS_W'(eff_fw)));
	assign last_col = (kx_q == eff_kw - K_W'(1));
	assign last_row = (ky_q == eff_kh - K_W'(1));
	assign out_free = !res_valid_q || res_ready;
	assign last_out = (out_pos_q + POS_W'(1) == total);

	always_comb begin
		coef_use = cvld_s1 ? coef_rd_q : 16'sd0;
		prod[0] = coef_use * $signed({1'b0, ring_rd_q[31:24]});
		prod[1] = coef_use * $signed({1'b0, ring_rd_q[23:16]});
		prod[2] = coef_use * $signed({1'b0, ring_rd_q[15:8]});
		sweep_next = sweep_acc_q;
		if (sweep_s1 && (sidx_s1 < n_taps)) begin
			sweep_next = sweep_acc_q + TOT_W'(coef_use);
		end
	end

	always_comb begin
		sum_sel = acc_q[0];
		case (ch_q)
			2'd1: sum_sel = acc_q[1];
			2'd2: sum_sel = acc_q[2];
			default: sum_sel = acc_q[0];
		endcase
		zs = ((ACC_W + 1)'(sum_sel) + (ACC_W + 1)'(128)) >>> 8;
		if (zs < 0) begin
			zsat = 8'd0;
		end else if (zs > 255) begin
			zsat = 8'd255;
		end else begin
			zsat = zs[7:0];
		end
		n2 = (NUM_W'(sum_sel) <<< 1) + NUM_W'(coef_total_q);
		tabs = (TOT_W + 1)'(coef_total_q);
		if (coef_total_q < 0) begin
			n2 = -n2;
			tabs = -tabs;
		end
		lim = NUM_W'(den_q) << 8;
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= {pix.in_red, pix.in_green, pix.in_blue, pix.in_alpha};
		end
		ring_rd_q <= ring_mem[ring_raddr];
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[CA_W'(pix.coef_index)] <= pix.coef_value;
		end
		coef_rd_q <= coef_mem[coef_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fw_q         <= 11'd1024;
			fh_q         <= 13'd1024;
			kw_q         <= 3'd3;
			kh_q         <= 3'd3;
			coef_vld_q   <= '0;
			coef_total_q <= '0;
			sweep_acc_q  <= '0;
			sc_q         <= '0;
			sweep_s1     <= 1'b0;
			sidx_s1      <= '0;
			cvld_s1      <= 1'b0;
			in_pos_q     <= '0;
			out_pos_q    <= '0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			tap_x_q      <= '0;
			tap_y_q      <= '0;
			row_addr_q   <= '0;
			tap_addr_q   <= '0;
			kx_q         <= '0;
			ky_q         <= '0;
			ci_q         <= '0;
			tap_s1       <= 1'b0;
			alpha_s1     <= 1'b0;
			alpha_q      <= '0;
			acc_q        <= '{default: '0};
			ch_q         <= '0;
			num_q        <= '0;
			den_q        <= '0;
			rem_q        <= '0;
			dsh_q        <= '0;
			bit_q        <= '0;
			quo_q        <= '0;
			chan_q       <= '{default: '0};
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			sweep_s1 <= 1'b0;
			tap_s1   <= 1'b0;
			alpha_s1 <= 1'b0;
			sidx_s1  <= sc_q;
			cvld_s1  <= coef_vld_q[coef_raddr];

			if (sweep_s1) begin
				sweep_acc_q <= sweep_next;
			end
			if (tap_s1) begin
				acc_q[0] <= acc_q[0] + ACC_W'(prod[0]);
				acc_q[1] <= acc_q[1] + ACC_W'(prod[1]);
				acc_q[2] <= acc_q[2] + ACC_W'(prod[2]);
			end
			if (alpha_s1) begin
				alpha_q <= ring_rd_q[7:0];
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pix_xfer) begin
						if (coef_we) begin
							coef_vld_q[CA_W'(pix.coef_index)] <= 1'b1;
							sc_q        <= '0;
							sweep_acc_q <= '0;
							state_q     <= ST_SWEEP;
						end
						if (pix_take) begin
							in_pos_q <= in_next;
						end
						if (emit_px || emit_drain) begin
							state_q <= ST_START;
						end
					end
				end
				ST_SWEEP: begin
					sweep_s1 <= 1'b1;
					sc_q     <= sc_q + CC_W'(1);
					if (32'(sc_q) == COEF_COUNT - 1) begin
						state_q <= ST_SWEEP_END;
					end
				end
				ST_SWEEP_END: begin
					coef_total_q <= sweep_next;
					state_q      <= ST_IDLE;
				end
				ST_START: begin
					alpha_s1   <= 1'b1;
					acc_q      <= '{default: '0};
					tap_x_q    <= $signed(XS_W'(out_x_q)) - $signed(XS_W'(hw));
					tap_y_q    <= $signed(YS_W'(out_y_q)) - $signed(YS_W'(hh));
					row_addr_q <= RING_AW'(out_pos_q - lag);
					tap_addr_q <= RING_AW'(out_pos_q - lag);
					kx_q       <= '0;
					ky_q       <= '0;
					ci_q       <= '0;
					state_q    <= ST_TAP;
				end
				ST_TAP: begin
					tap_s1 <= tap_ok;
					ci_q   <= ci_q + CC_W'(1);
					if (last_col) begin
						kx_q       <= '0;
						ky_q       <= ky_q + K_W'(1);
						tap_x_q    <= $signed(XS_W'(out_x_q)) - $signed(XS_W'(hw));
						tap_y_q    <= tap_y_q + YS_W'(1);
						row_addr_q <= row_addr_q + RING_AW'(eff_fw);
						tap_addr_q <= row_addr_q + RING_AW'(eff_fw);
						if (last_row) begin
							state_q <= ST_TAP_END;
						end
					end else begin
						kx_q       <= kx_q + K_W'(1);
						tap_x_q    <= tap_x_q + XS_W'(1);
						tap_addr_q <= tap_addr_q + RING_AW'(1);
					end
				end
				ST_TAP_END: begin
					ch_q    <= '0;
					state_q <= ST_DIV_INIT;
				end
				ST_DIV_INIT: begin
					if (coef_total_q == 0) begin
						chan_q[ch_q] <= zsat;
						if (ch_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end else begin
						num_q   <= n2;
						den_q   <= {tabs[TOT_W-1:0], 1'b0};
						state_q <= ST_DIV_CHK;
					end
				end
				ST_DIV_CHK: begin
					if (num_q < 0 || $unsigned(num_q) >= lim) begin
						chan_q[ch_q] <= (num_q < 0) ? 8'd0 : 8'd255;
						if (ch_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= ST_DIV_INIT;
						end
					end else begin
						rem_q   <= $unsigned(num_q);
						dsh_q   <= NUM_W'(den_q) << 7;
						bit_q   <= 3'd7;
						quo_q   <= '0;
						state_q <= ST_DIV_STEP;
					end
				end
				ST_DIV_STEP: begin
					dsh_q <= dsh_q >> 1;
					bit_q <= bit_q - 3'd1;
					if (rem_q >= dsh_q) begin
						rem_q        <= rem_q - dsh_q;
						quo_q[bit_q] <= 1'b1;
					end
					if (bit_q == 3'd0) begin
						chan_q[ch_q] <= quo_q | ((rem_q >= dsh_q) ? 8'd1 : 8'd0);
						if (ch_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= ST_DIV_INIT;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_valid_q      <= 1'b1;
						res_q.out_red    <= chan_q[0];
						res_q.out_green  <= chan_q[1];
						res_q.out_blue   <= chan_q[2];
						res_q.out_alpha  <= alpha_q;
						res_q.frame_done <= last_out;
						if (last_out) begin
							in_pos_q  <= '0;
							out_pos_q <= '0;
							out_x_q   <= '0;
							out_y_q   <= '0;
						end else begin
							out_pos_q <= out_pos_q + POS_W'(1);
							if (out_x_q == eff_fw - W_W'(1)) begin
								out_x_q <= '0;
								out_y_q <= out_y_q + 13'd1;
							end else begin
								out_x_q <= out_x_q + W_W'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cfg_we) begin
				unique case (cfg_index)
					rkc_pkg::CFG_FRAME_WIDTH:   fw_q <= cfg_data[10:0];
					rkc_pkg::CFG_FRAME_HEIGHT:  fh_q <= cfg_data[12:0];
					rkc_pkg::CFG_KERNEL_WIDTH:  kw_q <= cfg_data[2:0];
					rkc_pkg::CFG_KERNEL_HEIGHT: kh_q <= cfg_data[2:0];
					default: fw_q <= fw_q;
				endcase
				in_pos_q    <= '0;
				out_pos_q   <= '0;
				out_x_q     <= '0;
				out_y_q     <= '0;
				sc_q        <= '0;
				sweep_acc_q <= '0;
				sweep_s1    <= 1'b0;
				state_q     <= ST_SWEEP;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

// File: design/rkc_checker.sv
module rkc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pix_valid,
	input logic          pix_ready,
	input rkc_pkg::pix_t pix,
	input logic          res_valid,
	input logic          res_ready,
	input rkc_pkg::res_t res,
	input logic          cfg_we
);

	// held result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// a config write starts the coefficient sum rebuild
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !pix_ready)
		else $error("input ready right after config write");

	// a new result only comes out of the compute sequence
	a_res_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(pix_ready))
		else $error("result appeared while input side idle");

	// an ignored function code never leaves the block busy
	a_none_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && (pix.func == rkc_pkg::FUNC_NONE) && !cfg_we |=> pix_ready)
		else $error("unknown function code stalled the input");

endmodule

bind rgb_kernel_convolution rkc_checker u_rkc_checker (.*);
